FILE: design/hpi_pkg.sv
package hpi_pkg;

   localparam int HalfTurn = 23040;
   localparam int FullTurn = 46080;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN       = 3'd0,
      CSR_INTEG_GAIN      = 3'd1,
      CSR_INTEG_LIMIT     = 3'd2,
      CSR_INTEG_ON_BELOW  = 3'd3,
      CSR_INTEG_OFF_ABOVE = 3'd4,
      CSR_STEER_LIMIT     = 3'd5,
      CSR_SPEED_LIMIT     = 3'd6,
      CSR_STEP_TIME       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] heading_ref;
      logic signed [15:0] heading_est;
      logic signed [15:0] speed_request;
   } req_beat_type;

   typedef struct packed {
      logic signed [15:0] steer_cmd;
      logic [15:0]        speed_cmd;
      logic               integ_active;
   } rsp_beat_type;

   typedef struct packed {
      csr_index_type index;
      logic [23:0]   value;
   } csr_beat_type;

endpackage

FILE: design/hpi_chan_if.sv
interface hpi_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/heading_pi_with_gated_integrator.sv
// A request beat is taken only in IDLE; the sequencer then runs WRAP, MDT,
// INT, MGI, SUM, MLO, MHI, ACC and OUT, which registers the response. A
// single shared 17x26 multiplier is stepped four times per beat (dt, gI,
// kP low and high half). Reset (synchronous, active high) clears all but
// datapath registers; any configuration write clears integrator and enable.
module heading_pi_with_gated_integrator (
   input  logic        clock,
   input  logic        reset,
   hpi_chan_if.sink    req_if,
   hpi_chan_if.source  rsp_if,
   hpi_chan_if.sink    csr_if
);

   typedef enum logic [3:0] {
      S_IDLE, S_WRAP, S_MDT, S_INT, S_MGI, S_SUM, S_MLO, S_MHI, S_ACC, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] prop_gain_ff, prop_gain_in;
   logic [15:0] integ_gain_ff, integ_gain_in;
   logic [23:0] integ_limit_ff, integ_limit_in;
   logic [14:0] on_below_ff, on_below_in;
   logic [14:0] off_above_ff, off_above_in;
   logic [14:0] steer_limit_ff, steer_limit_in;
   logic [15:0] speed_limit_ff, speed_limit_in;
   logic [15:0] step_time_ff, step_time_in;

   logic signed [24:0] integ_ff, integ_in;
   logic               en_ff, en_in;

   logic signed [17:0] diff_ff, diff_in;
   logic signed [15:0] e_ff, e_in;
   logic [15:0]        speed_ff, speed_in;
   logic signed [42:0] prod_ff, prod_in;
   logic [36:0]        lo_ff, lo_in;
   logic signed [40:0] sum_ff, sum_in;
   logic signed [41:0] y_ff, y_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   hpi_pkg::rsp_beat_type   rsp_data_ff, rsp_data_in;

   logic signed [16:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [17:0] wrap_m;
   logic [15:0]        e_neg;
   logic [14:0]        eabs;
   logic signed [42:0] rnd;
   logic signed [25:0] isum, ilim;
   logic [57:0]        total;
   logic signed [41:0] slim;
   logic signed [15:0] steer;
   logic               csr_fire, req_fire;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign req_fire = req_if.valid && req_if.ready;
   assign csr_fire = csr_if.valid && csr_if.ready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MDT: begin
            mul_a = signed'({1'b0, step_time_ff});
            mul_b = 26'(e_ff);
         end
         S_MGI: begin
            mul_a = signed'({1'b0, integ_gain_ff});
            mul_b = 26'(integ_ff);
         end
         S_MLO: begin
            mul_a = signed'({1'b0, prop_gain_ff});
            mul_b = signed'({5'b0, sum_ff[20:0]});
         end
         S_MHI: begin
            mul_a = signed'({1'b0, prop_gain_ff});
            mul_b = 26'(signed'(sum_ff[40:21]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      prop_gain_in   = prop_gain_ff;
      integ_gain_in  = integ_gain_ff;
      integ_limit_in = integ_limit_ff;
      on_below_in    = on_below_ff;
      off_above_in   = off_above_ff;
      steer_limit_in = steer_limit_ff;
      speed_limit_in = speed_limit_ff;
      step_time_in   = step_time_ff;
      integ_in       = integ_ff;
      en_in          = en_ff;
      diff_in        = diff_ff;
      e_in           = e_ff;
      speed_in       = speed_ff;
      prod_in        = prod_ff;
      lo_in          = lo_ff;
      sum_in         = sum_ff;
      y_in           = y_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      wrap_m = diff_ff;
      if (diff_ff < 18'sd0) begin
         wrap_m = diff_ff + 18'(hpi_pkg::FullTurn);
      end else if (diff_ff >= 18'(hpi_pkg::FullTurn)) begin
         wrap_m = diff_ff - 18'(hpi_pkg::FullTurn);
      end
      e_neg = 16'(-e_ff);
      eabs  = e_ff[15] ? e_neg[14:0] : e_ff[14:0];
      rnd   = prod_ff + 43'sd32768;
      ilim  = signed'({2'b0, integ_limit_ff});
      isum  = 26'(integ_ff) + 26'(signed'(rnd[32:16]));
      total = {prod_ff[36:0], 21'b0} + {21'b0, lo_ff} + 58'd32768;
      slim  = signed'({27'b0, steer_limit_ff});
      steer = y_ff[15:0];
      if (y_ff > slim) begin
         steer = signed'({1'b0, steer_limit_ff});
      end else if (y_ff < -slim) begin
         steer = 16'(-slim);
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               diff_in = 18'(req_if.data.heading_ref) - 18'(req_if.data.heading_est)
                         + 18'(hpi_pkg::HalfTurn);
               if (req_if.data.speed_request[15]) begin
                  speed_in = '0;
               end else if ({1'b0, req_if.data.speed_request[14:0]} > speed_limit_ff) begin
                  speed_in = speed_limit_ff;
               end else begin
                  speed_in = {1'b0, req_if.data.speed_request[14:0]};
               end
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            e_in     = 16'(wrap_m - 18'(hpi_pkg::HalfTurn));
            state_in = S_MDT;
         end
         S_MDT: begin
            // off test wins over on test
            if (eabs > off_above_ff) begin
               en_in = 1'b0;
            end else if (eabs < on_below_ff) begin
               en_in = 1'b1;
            end
            prod_in  = mul_a * mul_b;
            state_in = S_INT;
         end
         S_INT: begin
            if (!en_ff) begin
               integ_in = '0;
            end else if (isum > ilim) begin
               integ_in = 25'(ilim);
            end else if (isum < -ilim) begin
               integ_in = 25'(-ilim);
            end else begin
               integ_in = 25'(isum);
            end
            state_in = S_MGI;
         end
         S_MGI: begin
            prod_in  = mul_a * mul_b;
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in   = prod_ff[40:0] + {{17{e_ff[15]}}, e_ff, 8'b0};
            state_in = S_MLO;
         end
         S_MLO: begin
            prod_in  = mul_a * mul_b;
            state_in = S_MHI;
         end
         S_MHI: begin
            lo_in    = prod_ff[36:0];
            prod_in  = mul_a * mul_b;
            state_in = S_ACC;
         end
         S_ACC: begin
            y_in     = signed'(total[57:16]);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.steer_cmd    = steer;
               rsp_data_in.speed_cmd    = speed_ff;
               rsp_data_in.integ_active = en_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_fire) begin
         case (csr_if.data.index)
            hpi_pkg::CSR_PROP_GAIN:       prop_gain_in   = csr_if.data.value[15:0];
            hpi_pkg::CSR_INTEG_GAIN:      integ_gain_in  = csr_if.data.value[15:0];
            hpi_pkg::CSR_INTEG_LIMIT:     integ_limit_in = csr_if.data.value;
            hpi_pkg::CSR_INTEG_ON_BELOW:  on_below_in    = csr_if.data.value[14:0];
            hpi_pkg::CSR_INTEG_OFF_ABOVE: off_above_in   = csr_if.data.value[14:0];
            hpi_pkg::CSR_STEER_LIMIT:     steer_limit_in = csr_if.data.value[14:0];
            hpi_pkg::CSR_SPEED_LIMIT:     speed_limit_in = csr_if.data.value[15:0];
            hpi_pkg::CSR_STEP_TIME:       step_time_in   = csr_if.data.value[15:0];
            default:                      step_time_in   = step_time_ff;
         endcase
         integ_in = '0;
         en_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         integ_limit_ff <= '0;
         on_below_ff    <= '0;
         off_above_ff   <= '0;
         steer_limit_ff <= '0;
         speed_limit_ff <= '0;
         step_time_ff   <= '0;
         integ_ff       <= '0;
         en_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prop_gain_ff   <= prop_gain_in;
         integ_gain_ff  <= integ_gain_in;
         integ_limit_ff <= integ_limit_in;
         on_below_ff    <= on_below_in;
         off_above_ff   <= off_above_in;
         steer_limit_ff <= steer_limit_in;
         speed_limit_ff <= speed_limit_in;
         step_time_ff   <= step_time_in;
         integ_ff       <= integ_in;
         en_ff          <= en_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      diff_ff     <= diff_in;
      e_ff        <= e_in;
      speed_ff    <= speed_in;
      prod_ff     <= prod_in;
      lo_ff       <= lo_in;
      sum_ff      <= sum_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_integ_in_limit: assert property (@(posedge clock) disable iff (reset)
      (26'(integ_ff) <= signed'({2'b0, integ_limit_ff}))
      && (26'(integ_ff) >= -signed'({2'b0, integ_limit_ff})))
      else $error("integrator outside its clamp");

   a_integ_cleared_when_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MGI && !en_ff) |-> (integ_ff == 25'sd0))
      else $error("integrator not cleared while disabled");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response beat raised outside output state");
`endif

endmodule
